[rtl/dcms_pkg.sv]
// Shared types and constants for the message cache scheduler.
package dcms_pkg;

	localparam int VALUE_W   = 64;
	localparam int COUNT_W   = 32;
	localparam int TIME_W    = 32;
	localparam int DUR_W     = 16;
	localparam int FACTOR_W  = 10;
	localparam int TYPE_W    = 4;
	localparam int PROD_W    = DUR_W + FACTOR_W;
	localparam int SLOT_W    = COUNT_W + VALUE_W;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W = 152;
	localparam int OUT_DATA_W = 72;

	localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR = 10'd100;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_FACTOR = 1'd1;

	localparam logic MODE_OLDEST = 1'b0;
	localparam logic MODE_ROBIN  = 1'b1;

	typedef enum logic [1:0] {
		OP_STORE   = 2'd0,
		OP_SERVICE = 2'd1,
		OP_DONE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic               went_to_next;
		logic               duty_ok;
		logic [VALUE_W-1:0] tx_value;
		logic [TYPE_W-1:0]  tx_type;
		logic               tx_start;
	} res_t;

endpackage

[rtl/dcms_ram.sv]
// Single-port-write, single-port-read slot memory with registered read data.
module dcms_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/dcms_cmp.sv]
// Shared 33-bit add-and-compare unit: lt = (a + b) < c without wrap.
module dcms_cmp (
	input  logic [dcms_pkg::TIME_W-1:0] a,
	input  logic [dcms_pkg::TIME_W-1:0] b,
	input  logic [dcms_pkg::TIME_W-1:0] c,
	output logic                        lt
);

	logic [dcms_pkg::TIME_W:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};
	assign lt  = sum < {1'b0, c};

endmodule

[rtl/duty_cycled_message_cache_scheduler_core.sv]
// Top level: message cache with duty-cycle gated transmit scheduling.
//
//  channel  dir  handshake              contents
//  s_*      in   s_tvalid / s_tready    tuser op, tdata store/service/done fields
//  m_*      out  m_tvalid / m_tready    tdata result word
//  cfg_*    in   cfg_we                 register index and write data
//
// Store, done, unknown op and a service that issues nothing at decode go from decode
// straight to the response state (through the promote state with a promotion).
// Oldest-first service walks every slot through the shared compare unit, one read
// per cycle from the current-slot memory.
// Round-robin service tests one ready bit per cycle, at most once per slot.
// Reset clears ready and next flags, timers and pointers; slot memories are not cleared.
// Input is taken only when the sequencer is idle; a result held in the output register
// stalls only the next item's response.
module duty_cycled_message_cache_scheduler_core #(
	parameter int NUM_TYPES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [3:0] msg_type, [67:4] payload, [99:68] seq_count, [131:100] now_ms,
	// [147:132] tx_duration_ms, [148] tx_ok
	input  logic [dcms_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] op
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] tx_start, [4:1] tx_type, [68:5] tx_value, [69] duty_ok, [70] went_to_next
	output logic [dcms_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [dcms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dcms_pkg::FACTOR_W-1:0]       cfg_wdata
);

	localparam int IDX_W  = $clog2(NUM_TYPES);
	localparam int SCAN_W = IDX_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_ROBIN,
		ST_FETCH,
		ST_LOAD,
		ST_PROMOTE,
		ST_RESP
	} state_t;

	state_t state_q;

	dcms_pkg::op_t                    op_q;
	logic [dcms_pkg::TYPE_W-1:0]      mt_q;
	logic [dcms_pkg::VALUE_W-1:0]     payload_q;
	logic [dcms_pkg::COUNT_W-1:0]     cnt_q;
	logic [dcms_pkg::TIME_W-1:0]      now_q;
	logic [dcms_pkg::DUR_W-1:0]       dur_q;
	logic                             ok_q;

	logic                             select_mode_q;
	logic [dcms_pkg::FACTOR_W-1:0]    pause_factor_q;
	logic [NUM_TYPES-1:0]             ready_q;
	logic [NUM_TYPES-1:0]             nxt_full_q;
	logic [dcms_pkg::TIME_W-1:0]      last_tx_q;
	logic [dcms_pkg::TIME_W-1:0]      pause_q;
	logic                             pending_q;
	logic [IDX_W-1:0]                 ptype_q;
	logic [IDX_W-1:0]                 rr_q;

	logic [SCAN_W-1:0]                scan_q;
	logic                             tag_s1;
	logic [IDX_W-1:0]                 idx_s1;
	logic [IDX_W-1:0]                 pick_q;
	logic [IDX_W-1:0]                 steps_q;
	logic [dcms_pkg::COUNT_W-1:0]     best_q;
	logic                             found_q;

	dcms_pkg::res_t                   res_q;
	dcms_pkg::res_t                   out_q;
	logic                             out_valid_q;

	logic [IDX_W-1:0]                 mt_idx;
	logic                             mt_in_range;
	logic [dcms_pkg::PROD_W-1:0]      prod;

	logic                             cur_we, cur_re, nxt_we, nxt_re;
	logic [IDX_W-1:0]                 cur_waddr, cur_raddr;
	logic [dcms_pkg::SLOT_W-1:0]      cur_wdata, cur_rdata, nxt_rdata;
	logic [dcms_pkg::COUNT_W-1:0]     rd_count;

	logic [dcms_pkg::TIME_W-1:0]      cmp_a, cmp_b, cmp_c;
	logic                             cmp_lt;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	assign mt_idx      = IDX_W'(mt_q);
	assign mt_in_range = (32'(mt_q) < NUM_TYPES);
	assign prod        = dur_q * pause_factor_q;
	assign rd_count    = cur_rdata[dcms_pkg::SLOT_W-1:dcms_pkg::VALUE_W];

	always_comb begin
		cur_we    = 1'b0;
		nxt_we    = 1'b0;
		cur_waddr = mt_idx;
		cur_wdata = {cnt_q, payload_q};
		if (state_q == ST_DECODE && op_q == dcms_pkg::OP_STORE && mt_in_range) begin
			cur_we = !ready_q[mt_idx];
			nxt_we = ready_q[mt_idx];
		end
		if (state_q == ST_PROMOTE) begin
			cur_we    = 1'b1;
			cur_waddr = ptype_q;
			cur_wdata = nxt_rdata;
		end
		cur_re    = (state_q == ST_SCAN) || (state_q == ST_FETCH);
		cur_raddr = (state_q == ST_FETCH) ? pick_q : scan_q[IDX_W-1:0];
		nxt_re    = (state_q == ST_DECODE) && (op_q == dcms_pkg::OP_DONE);
	end

	// gate check while decoding, slot count against best during the scan
	always_comb begin
		if (state_q == ST_DECODE) begin
			cmp_a = last_tx_q;
			cmp_b = pause_q;
			cmp_c = now_q;
		end else begin
			cmp_a = rd_count;
			cmp_b = '0;
			cmp_c = best_q;
		end
	end

	dcms_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.c  (cmp_c),
		.lt (cmp_lt)
	);

	dcms_ram #(
		.WIDTH (dcms_pkg::SLOT_W),
		.DEPTH (NUM_TYPES)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (cur_re),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	dcms_ram #(
		.WIDTH (dcms_pkg::SLOT_W),
		.DEPTH (NUM_TYPES)
	) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (mt_idx),
		.wdata ({cnt_q, payload_q}),
		.re    (nxt_re),
		.raddr (ptype_q),
		.rdata (nxt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= dcms_pkg::OP_NONE;
			mt_q           <= '0;
			payload_q      <= '0;
			cnt_q          <= '0;
			now_q          <= '0;
			dur_q          <= '0;
			ok_q           <= 1'b0;
			select_mode_q  <= dcms_pkg::MODE_OLDEST;
			pause_factor_q <= dcms_pkg::DEFAULT_FACTOR;
			ready_q        <= '0;
			nxt_full_q     <= '0;
			last_tx_q      <= '0;
			pause_q        <= '0;
			pending_q      <= 1'b0;
			ptype_q        <= '0;
			rr_q           <= '0;
			scan_q         <= '0;
			tag_s1         <= 1'b0;
			idx_s1         <= '0;
			pick_q         <= '0;
			steps_q        <= '0;
			best_q         <= '0;
			found_q        <= 1'b0;
			res_q          <= '0;
			out_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dcms_pkg::REG_SELECT_MODE:  select_mode_q  <= cfg_wdata[0];
					dcms_pkg::REG_PAUSE_FACTOR: pause_factor_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && m_tready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q      <= dcms_pkg::op_t'(s_tuser);
						mt_q      <= s_tdata[3:0];
						payload_q <= s_tdata[67:4];
						cnt_q     <= s_tdata[99:68];
						now_q     <= s_tdata[131:100];
						dur_q     <= s_tdata[147:132];
						ok_q      <= s_tdata[148];
						res_q     <= '0;
						state_q   <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					unique case (op_q)
						dcms_pkg::OP_STORE: begin
							state_q <= ST_RESP;
							if (mt_in_range) begin
								if (ready_q[mt_idx]) begin
									nxt_full_q[mt_idx] <= 1'b1;
									res_q.went_to_next <= 1'b1;
								end else begin
									ready_q[mt_idx] <= 1'b1;
								end
							end
						end
						dcms_pkg::OP_SERVICE: begin
							res_q.duty_ok <= cmp_lt;
							found_q       <= 1'b0;
							tag_s1        <= 1'b0;
							scan_q        <= '0;
							steps_q       <= '0;
							pick_q        <= (rr_q == IDX_W'(NUM_TYPES - 1)) ? '0 : rr_q + 1'b1;
							if (cmp_lt && !pending_q) begin
								state_q <= (select_mode_q == dcms_pkg::MODE_ROBIN) ? ST_ROBIN
								                                                     : ST_SCAN;
							end else begin
								state_q <= ST_RESP;
							end
						end
						dcms_pkg::OP_DONE: begin
							res_q.duty_ok <= cmp_lt;
							pause_q       <= dcms_pkg::TIME_W'(prod);
							last_tx_q     <= now_q;
							pending_q     <= 1'b0;
							if (pending_q && ok_q && select_mode_q == dcms_pkg::MODE_OLDEST &&
							    nxt_full_q[ptype_q]) begin
								nxt_full_q[ptype_q] <= 1'b0;
								state_q             <= ST_PROMOTE;
							end else begin
								state_q <= ST_RESP;
								if (pending_q && ok_q && select_mode_q == dcms_pkg::MODE_OLDEST) begin
									ready_q[ptype_q] <= 1'b0;
								end
							end
						end
						default: state_q <= ST_RESP;
					endcase
				end

				ST_SCAN: begin
					if (scan_q < SCAN_W'(NUM_TYPES)) begin
						tag_s1 <= ready_q[scan_q[IDX_W-1:0]];
						idx_s1 <= scan_q[IDX_W-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						tag_s1  <= 1'b0;
						state_q <= ST_FETCH;
					end
					if (tag_s1 && (!found_q || cmp_lt)) begin
						pick_q  <= idx_s1;
						best_q  <= rd_count;
						found_q <= 1'b1;
					end
				end

				ST_ROBIN: begin
					if (ready_q[pick_q]) begin
						found_q <= 1'b1;
						rr_q    <= pick_q;
						state_q <= ST_FETCH;
					end else if (steps_q == IDX_W'(NUM_TYPES - 1)) begin
						state_q <= ST_RESP;
					end else begin
						pick_q  <= (pick_q == IDX_W'(NUM_TYPES - 1)) ? '0 : pick_q + 1'b1;
						steps_q <= steps_q + 1'b1;
					end
				end

				ST_FETCH: begin
					state_q <= found_q ? ST_LOAD : ST_RESP;
				end

				ST_LOAD: begin
					res_q.tx_start <= 1'b1;
					res_q.tx_type  <= dcms_pkg::TYPE_W'(pick_q);
					res_q.tx_value <= cur_rdata[dcms_pkg::VALUE_W-1:0];
					pending_q      <= 1'b1;
					ptype_q        <= pick_q;
					state_q        <= ST_RESP;
				end

				ST_PROMOTE: begin
					state_q <= ST_RESP;
				end

				ST_RESP: begin
					if (!out_valid_q || m_tready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
